@@ design/contiguous_slot_bitmap_allocator_assert.svh @@
// Assertion macros shared by the slot allocator modules.
`ifndef CONTIGUOUS_SLOT_BITMAP_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_SLOT_BITMAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication: when cond holds, prop must hold.
`define CSBA_ASSERT_IMP(lbl, clk_i, rstn_i, cond, prop) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (cond) |-> (prop)) \
        else $error("allocator assertion failed");
// Next-cycle implication: when cond holds, prop must hold in the next cycle.
`define CSBA_ASSERT_NXT(lbl, clk_i, rstn_i, cond, prop) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (cond) |=> (prop)) \
        else $error("allocator assertion failed");
`else
`define CSBA_ASSERT_IMP(lbl, clk_i, rstn_i, cond, prop)
`define CSBA_ASSERT_NXT(lbl, clk_i, rstn_i, cond, prop)
`endif
`endif

@@ design/csba_pkg.sv @@
// Package with constants, types and helper functions of the slot allocator.
package csba_pkg;

    localparam int SLOTS  = 32;
    localparam int UNITS  = 2;
    localparam int MODE_W = 2;
    localparam int UNIT_W = 1;
    localparam int CNT_W  = 6;
    localparam int SLOT_W = 5;

    // Request modes.
    typedef enum logic [MODE_W-1:0] {
        MODE_FIND    = 2'd0,
        MODE_CHECK   = 2'd1,
        MODE_MARK    = 2'd2,
        MODE_RELEASE = 2'd3
    } mode_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_HOLD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic capture;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
        logic out_free;
    } status_t;

    typedef logic [SLOTS-1:0] map_t;

    // Mask of the n lowest slots; a count at or above SLOTS gives all slots.
    function automatic map_t low_ones(input logic [CNT_W-1:0] n);
        map_t m;
        for (int i = 0; i < SLOTS; i++)
        begin
            m[i] = (CNT_W'(i) < n);
        end
        return m;
    endfunction

endpackage

@@ design/csba_ctrl.sv @@
// Controller state machine of the slot allocator.
`include "contiguous_slot_bitmap_allocator_assert.svh"
module csba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  csba_pkg::status_t status,
    output csba_pkg::cmd_t    cmd
);

    csba_pkg::state_t state_reg;
    csba_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csba_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            csba_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = csba_pkg::ST_EVAL;
                end
            end
            csba_pkg::ST_EVAL:
            begin
                if (status.done)
                begin
                    state_next = csba_pkg::ST_HOLD;
                end
            end
            csba_pkg::ST_HOLD:
            begin
                if (status.out_free)
                begin
                    state_next = csba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = csba_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            csba_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            csba_pkg::ST_EVAL:
            begin
                cmd.step    = !status.done;
                cmd.capture = status.done;
            end
            csba_pkg::ST_HOLD:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `CSBA_ASSERT_NXT(a_accept_evals, clk, rst_n, in_valid && !in_stall, state_reg == csba_pkg::ST_EVAL)
    `CSBA_ASSERT_NXT(a_hold_drains, clk, rst_n, cmd.emit, state_reg == csba_pkg::ST_IDLE)
    `CSBA_ASSERT_IMP(a_step_xor_capture, clk, rst_n, cmd.step, !cmd.capture)

endmodule

@@ design/csba_dp.sv @@
// Datapath of the slot allocator: bitmaps, request registers, scan and result.
`include "contiguous_slot_bitmap_allocator_assert.svh"
module csba_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  csba_pkg::cmd_t               cmd,
    output csba_pkg::status_t            status,
    input  logic [csba_pkg::MODE_W-1:0]  mode,
    input  logic [csba_pkg::UNIT_W-1:0]  unit_index,
    input  logic [csba_pkg::CNT_W-1:0]   start_slot,
    input  logic [csba_pkg::CNT_W-1:0]   slot_count,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         found,
    output logic [csba_pkg::SLOT_W-1:0]  found_slot
);

    csba_pkg::map_t                 used_map_reg [csba_pkg::UNITS];
    csba_pkg::mode_t                mode_reg;
    logic [csba_pkg::UNIT_W-1:0]    unit_reg;
    logic [csba_pkg::CNT_W-1:0]     start_reg;
    logic [csba_pkg::CNT_W-1:0]     count_reg;
    logic [csba_pkg::CNT_W-1:0]     off_reg;
    logic                           res_found_reg;
    logic [csba_pkg::SLOT_W-1:0]    res_slot_reg;
    logic                           out_valid_reg;
    logic                           found_reg;
    logic [csba_pkg::SLOT_W-1:0]    found_slot_reg;

    csba_pkg::map_t                 map;
    csba_pkg::map_t                 mask;
    csba_pkg::map_t                 bits;
    logic [csba_pkg::CNT_W-1:0]     cand;
    logic                           range_ok;
    logic                           free;
    logic                           count_ok;
    logic                           hit;
    logic                           res_found;
    logic [csba_pkg::SLOT_W-1:0]    res_slot;
    logic                           find_hit_cap;
    logic                           run_fits;

    // Range test of the current candidate against the addressed bitmap.
    always_comb
    begin
        map  = used_map_reg[unit_reg];
        mask = csba_pkg::low_ones(count_reg);
        cand = (mode_reg == csba_pkg::MODE_FIND) ? off_reg : start_reg;
        range_ok = (start_reg <= csba_pkg::CNT_W'(csba_pkg::SLOTS))
                && (count_reg <= csba_pkg::CNT_W'(csba_pkg::SLOTS))
                && (({1'b0, start_reg} + {1'b0, count_reg})
                    <= (csba_pkg::CNT_W+1)'(csba_pkg::SLOTS));
        free     = ((map >> cand) & mask) == '0;
        count_ok = (count_reg != '0) && (count_reg <= csba_pkg::CNT_W'(csba_pkg::SLOTS));
        hit      = count_ok && free;
        bits     = (start_reg >= csba_pkg::CNT_W'(csba_pkg::SLOTS)) ? '0 : (mask << start_reg);
    end

    // Result of the request and the end-of-work flag.
    always_comb
    begin
        res_found   = 1'b0;
        res_slot    = '0;
        status.done = 1'b1;
        case (mode_reg)
            csba_pkg::MODE_FIND:
            begin
                res_found   = hit;
                res_slot    = hit ? off_reg[csba_pkg::SLOT_W-1:0] : '0;
                status.done = !count_ok || hit || (off_reg == '0);
            end
            csba_pkg::MODE_CHECK:
            begin
                res_found = range_ok && free;
            end
            default:
            begin
                res_found = 1'b0;
            end
        endcase
        status.out_free = !out_valid_reg || !out_stall;
    end

    // A run found by a scan must end inside the map.
    always_comb
    begin
        find_hit_cap = cmd.capture && (mode_reg == csba_pkg::MODE_FIND) && res_found;
        run_fits     = ((csba_pkg::CNT_W+1)'(res_slot) + (csba_pkg::CNT_W+1)'(count_reg))
                       <= (csba_pkg::CNT_W+1)'(csba_pkg::SLOTS);
    end

    // Request registers and the downward scan offset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= csba_pkg::mode_t'(mode);
            unit_reg  <= unit_index;
            start_reg <= start_slot;
            count_reg <= slot_count;
            off_reg   <= csba_pkg::CNT_W'(csba_pkg::SLOTS) - slot_count;
        end
        else if (cmd.step)
        begin
            off_reg <= off_reg - csba_pkg::CNT_W'(1);
        end
    end

    // Bitmaps: cleared at reset, updated once per mark or release.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int u = 0; u < csba_pkg::UNITS; u++)
            begin
                used_map_reg[u] <= '0;
            end
        end
        else if (cmd.capture)
        begin
            if (mode_reg == csba_pkg::MODE_MARK)
            begin
                used_map_reg[unit_reg] <= map | bits;
            end
            else if (mode_reg == csba_pkg::MODE_RELEASE)
            begin
                used_map_reg[unit_reg] <= map & ~bits;
            end
        end
    end

    // Result hold registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            res_found_reg <= res_found;
            res_slot_reg  <= res_slot;
        end
        if (cmd.emit)
        begin
            found_reg      <= res_found_reg;
            found_slot_reg <= res_slot_reg;
        end
    end

    // Output beat valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign found_slot = found_slot_reg;

    `CSBA_ASSERT_IMP(a_run_fits, clk, rst_n, find_hit_cap, run_fits)
    `CSBA_ASSERT_IMP(a_valid_from_emit, clk, rst_n, $rose(out_valid_reg), $past(cmd.emit))
    `CSBA_ASSERT_IMP(a_slot_zero_unfound, clk, rst_n, out_valid_reg && !found_reg, !(|found_slot_reg))

endmodule

@@ design/contiguous_slot_bitmap_allocator.sv @@
// Top level of the contiguous slot bitmap allocator.
// Each request is loaded, evaluated, held and then sent as a result beat; find
// scans one candidate offset per cycle downward until a free run or offset 0.
// One request at a time: the next is taken once the last one leaves hold.
// Reset (rst_n low, asynchronous) clears both bitmaps to all free at once.
module contiguous_slot_bitmap_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [csba_pkg::MODE_W-1:0]  mode,
    input  logic [csba_pkg::UNIT_W-1:0]  unit_index,
    input  logic [csba_pkg::CNT_W-1:0]   start_slot,
    input  logic [csba_pkg::CNT_W-1:0]   slot_count,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         found,
    output logic [csba_pkg::SLOT_W-1:0]  found_slot
);

    csba_pkg::cmd_t    cmd;
    csba_pkg::status_t status;

    // Sequencer.
    csba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Bitmaps and scan datapath.
    csba_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .mode       (mode),
        .unit_index (unit_index),
        .start_slot (start_slot),
        .slot_count (slot_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found      (found),
        .found_slot (found_slot)
    );

endmodule

@@ dv/contiguous_slot_bitmap_allocator_tb.sv @@
// Self-checking testbench for the contiguous slot bitmap allocator.
module contiguous_slot_bitmap_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_REPORTS    = 10;

    // One predicted result beat.
    typedef struct {
        logic                        found;
        logic [csba_pkg::SLOT_W-1:0] slot;
    } alloc_answer_t;

    // A run that the allocation sequences hold and later give back.
    typedef struct {
        logic unit;
        int   first;
        int   n;
    } held_run_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [csba_pkg::MODE_W-1:0]   mode = '0;
    logic [csba_pkg::UNIT_W-1:0]   unit_index = '0;
    logic [csba_pkg::CNT_W-1:0]    start_slot = '0;
    logic [csba_pkg::CNT_W-1:0]    slot_count = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          found;
    logic [csba_pkg::SLOT_W-1:0]   found_slot;

    // Predicted slot maps and the results still owed by the block.
    csba_pkg::map_t      used_slots [csba_pkg::UNITS] = '{default: '0};
    alloc_answer_t       answer_q [$];
    alloc_answer_t       oldest_answer;
    int                  fail_count = 0;
    int                  idle_pct = 0;
    int                  stall_left = 0;
    int                  idle_cycles = 0;

    contiguous_slot_bitmap_allocator u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .unit_index (unit_index),
        .start_slot (start_slot),
        .slot_count (slot_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found      (found),
        .found_slot (found_slot)
    );

    always #5 clk = ~clk;

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) >= idle_pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // A range is free only when it lies inside the map and no slot in it is used.
    function automatic logic range_is_free(csba_pkg::map_t map, int first, int n);
        if (first > csba_pkg::SLOTS || n > csba_pkg::SLOTS || first + n > csba_pkg::SLOTS)
            return 1'b0;
        for (int i = first; i < first + n; i++)
        begin
            if (map[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Slots covered by a range; anything past the top slot falls away.
    function automatic csba_pkg::map_t span_bits(int first, int n);
        csba_pkg::map_t bits;
        bits = '0;
        for (int i = 0; i < csba_pkg::SLOTS; i++)
        begin
            bits[i] = (i >= first) && (i < first + n);
        end
        return bits;
    endfunction

    // Predict one request and update the predicted maps.
    function automatic alloc_answer_t apply_request(csba_pkg::mode_t m, logic u,
                                                    int first, int n);
        alloc_answer_t  ans;
        csba_pkg::map_t map;
        int             off;
        ans.found = 1'b0;
        ans.slot  = '0;
        map = used_slots[u];
        case (m)
            csba_pkg::MODE_FIND:
            begin
                // Scan from the highest fitting offset down to slot 0.
                if (n != 0 && n <= csba_pkg::SLOTS)
                begin
                    off = csba_pkg::SLOTS - n;
                    while (off >= 0 && !ans.found)
                    begin
                        if (range_is_free(map, off, n))
                        begin
                            ans.found = 1'b1;
                            ans.slot  = csba_pkg::SLOT_W'(off);
                        end
                        off--;
                    end
                end
            end
            csba_pkg::MODE_CHECK:
                ans.found = range_is_free(map, first, n);
            csba_pkg::MODE_MARK:
                used_slots[u] = map | span_bits(first, n);
            default:
                used_slots[u] = map & ~span_bits(first, n);
        endcase
        return ans;
    endfunction

    // Send one request beat, predict it on acceptance, then idle at random.
    task automatic issue_request(input csba_pkg::mode_t m, input logic u, input int first,
                                 input int n, output alloc_answer_t ans);
        int gap;
        in_valid   <= 1'b1;
        mode       <= m;
        unit_index <= u;
        start_slot <= csba_pkg::CNT_W'(first);
        slot_count <= csba_pkg::CNT_W'(n);
        do
            @(posedge clk);
        while (in_stall);
        ans = apply_request(m, u, first & 63, n & 63);
        answer_q.push_back(ans);
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Field extremes, every mode and each corner of range handling.
    task automatic test_directed_corners();
        alloc_answer_t ans;
        idle_pct = 20;
        issue_request(csba_pkg::MODE_FIND, 1'b0, 0, 0, ans);      // zero count is never found
        issue_request(csba_pkg::MODE_FIND, 1'b0, 63, 32, ans);    // whole map on empty unit
        issue_request(csba_pkg::MODE_FIND, 1'b1, 0, 1, ans);      // highest single slot
        issue_request(csba_pkg::MODE_FIND, 1'b0, 0, 33, ans);     // count above the map
        issue_request(csba_pkg::MODE_FIND, 1'b1, 0, 63, ans);
        issue_request(csba_pkg::MODE_CHECK, 1'b0, 0, 0, ans);     // empty valid range is free
        issue_request(csba_pkg::MODE_CHECK, 1'b0, 32, 0, ans);    // empty range at the top
        issue_request(csba_pkg::MODE_CHECK, 1'b0, 33, 0, ans);    // start past the top
        issue_request(csba_pkg::MODE_CHECK, 1'b1, 0, 33, ans);
        issue_request(csba_pkg::MODE_CHECK, 1'b1, 20, 13, ans);   // range runs over the top
        issue_request(csba_pkg::MODE_CHECK, 1'b1, 0, 32, ans);
        issue_request(csba_pkg::MODE_MARK, 1'b0, 0, 32, ans);     // full-width mask
        issue_request(csba_pkg::MODE_FIND, 1'b0, 0, 1, ans);
        issue_request(csba_pkg::MODE_FIND, 1'b1, 0, 32, ans);
        issue_request(csba_pkg::MODE_RELEASE, 1'b0, 16, 63, ans); // bits past the top dropped
        issue_request(csba_pkg::MODE_FIND, 1'b0, 0, 16, ans);
        issue_request(csba_pkg::MODE_MARK, 1'b0, 32, 5, ans);     // start at the top: no change
        issue_request(csba_pkg::MODE_MARK, 1'b1, 63, 63, ans);
        issue_request(csba_pkg::MODE_RELEASE, 1'b0, 40, 10, ans);
        issue_request(csba_pkg::MODE_CHECK, 1'b0, 63, 63, ans);
        issue_request(csba_pkg::MODE_MARK, 1'b0, 30, 5, ans);
        issue_request(csba_pkg::MODE_FIND, 1'b0, 0, 16, ans);
        issue_request(csba_pkg::MODE_FIND, 1'b0, 0, 14, ans);
        issue_request(csba_pkg::MODE_RELEASE, 1'b0, 0, 32, ans);
        issue_request(csba_pkg::MODE_CHECK, 1'b0, 0, 32, ans);
    endtask

    // Find, mark and check runs, then give them back, with some noise between.
    task automatic test_alloc_cycles(input int n_items);
        alloc_answer_t ans;
        held_run_t     held [$];
        held_run_t     run;
        int            sent;
        int            phase_end;
        int            pick;
        int            k;
        logic          u;
        sent = 0;
        phase_end = 0;
        while (sent < n_items)
        begin
            // Alternate stretches with and without idling.
            if (sent >= phase_end)
            begin
                idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : 35;
                phase_end = sent + 100;
            end
            pick = $urandom_range(0, 9);
            u    = 1'($urandom_range(0, 1));
            if (pick < 5)
            begin
                run.unit = u;
                run.n    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32)
                                                       : $urandom_range(1, 8);
                issue_request(csba_pkg::MODE_FIND, u, $urandom_range(0, 63), run.n, ans);
                sent++;
                if (ans.found)
                begin
                    run.first = int'(ans.slot);
                    issue_request(csba_pkg::MODE_MARK, u, run.first, run.n, ans);
                    issue_request(csba_pkg::MODE_CHECK, u, run.first, run.n, ans);
                    held.push_back(run);
                    sent += 2;
                end
            end
            else if (pick < 8 && held.size() != 0)
            begin
                k   = $urandom_range(0, held.size() - 1);
                run = held[k];
                held.delete(k);
                issue_request(csba_pkg::MODE_CHECK, run.unit, run.first, run.n, ans);
                issue_request(csba_pkg::MODE_RELEASE, run.unit, run.first, run.n, ans);
                issue_request(csba_pkg::MODE_CHECK, run.unit, run.first, run.n, ans);
                sent += 3;
            end
            else
            begin
                issue_request(csba_pkg::mode_t'($urandom_range(0, 3)), u,
                              $urandom_range(0, 1) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, 32),
                              $urandom_range(0, 1) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, 33), ans);
                sent++;
            end
        end
    endtask

    // Fully random beats under heavy idling on both sides.
    task automatic test_random_noise(input int n_items);
        alloc_answer_t ans;
        idle_pct = 60;
        for (int i = 0; i < n_items; i++)
        begin
            issue_request(csba_pkg::mode_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 63), $urandom_range(0, 63), ans);
        end
    endtask

    // Result-side back-pressure.
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else
            stall_left <= pick_gap();
        out_stall <= (stall_left != 0);
    end

    // Compare each result beat against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (answer_q.size() == 0)
            begin
                note_failure($sformatf("unexpected result beat: found=%0b slot=%0d",
                                       found, found_slot));
            end
            else
            begin
                oldest_answer = answer_q.pop_front();
                if (found !== oldest_answer.found || found_slot !== oldest_answer.slot)
                    note_failure($sformatf(
                        "mismatch: expected found=%0b slot=%0d, got found=%0b slot=%0d",
                        oldest_answer.found, oldest_answer.slot, found, found_slot));
            end
        end
    end

    // Give up when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_alloc_cycles(950);
        test_random_noise(300);
        in_valid <= 1'b0;
        // Let the outstanding results come back, then watch for strays.
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && answer_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/csba_pkg.sv
design/csba_ctrl.sv
design/csba_dp.sv
design/contiguous_slot_bitmap_allocator.sv
dv/contiguous_slot_bitmap_allocator_tb.sv
